// ----- rtl/iiga_pkg.sv -----
// Shared constants for the IOVA interval gap allocator.
package iiga_pkg;

   localparam int MAX_RANGES_DEFAULT = 64;
   localparam int CSR_ADDR_W         = 3;
   localparam logic [31:0] MIN_GAP_RESET = 32'd4096;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_FIND   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_DUP   = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // register index, taken from paddr[2]
   localparam logic REG_MIN_GAP = 1'b0;

endpackage

// ----- rtl/iova_interval_gap_allocator.sv -----
// Top level: range table with free-gap marking, scanned one slot per cycle.
//
//  channel  | dir | handshake                  | payload
//  req_     | in  | req_tvalid / req_tready    | tuser opcode, tdata start, length
//  rsp_     | out | rsp_tvalid / rsp_tready    | tuser status, tdata free address
//  csr_     | in  | psel / penable, pready = 1 | min_gap at byte address 0
//
// Insert, remove and find make a full pass over the table memories (one slot read per
// cycle, registered read data); insert and remove then re-check neighbors in S_REC_P
// and, for insert, S_REC_N. Clear skips the scan. req_tready is high only in idle.
// A finished result sits in the output register; the next item is taken meanwhile.
// Reset (synchronous) empties the table and sets min_gap to 4096.
module iova_interval_gap_allocator #(
   parameter int MAX_RANGES = iiga_pkg::MAX_RANGES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [127:0]                    req_tdata,  // start_address, range_length
   input  logic [1:0]                      req_tuser,  // opcode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [63:0]                     rsp_tdata,  // free_address
   output logic [1:0]                      rsp_tuser,  // status
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [iiga_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import iiga_pkg::*;

   localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CNT_W = $clog2(MAX_RANGES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_RANGES - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_EVAL, S_REC_P, S_REC_N, S_DONE
   } state_type;

   state_type state_ff;

   // table memories
   logic [63:0] start_mem [MAX_RANGES];
   logic [63:0] length_mem[MAX_RANGES];
   logic [31:0] stamp_mem [MAX_RANGES];

   logic [MAX_RANGES-1:0] valid_ff, onfree_ff;
   logic [31:0] min_gap_ff, stamp_ff;

   // request
   opcode_type  op_ff;
   logic [63:0] key_ff, len_ff;

   // scan
   logic [CNT_W-1:0] scan_ff;
   logic             rd_vld_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [63:0]      rd_start_ff, rd_len_ff;
   logic [31:0]      rd_stamp_ff;

   logic             match_ff, free_ff, has_p_ff, has_n_ff, has_b_ff;
   logic [IDX_W-1:0] match_idx_ff, free_idx_ff, p_idx_ff;
   logic [63:0]      p_start_ff, p_len_ff, n_start_ff, b_start_ff, b_len_ff;
   logic [31:0]      b_age_ff;

   logic [63:0] rec_head_ff, end_a_ff, end_b_ff;
   status_type  status_ff;
   logic [63:0] addr_ff;

   logic        rsp_valid_ff;
   logic [63:0] rsp_addr_ff;
   status_type  rsp_status_ff;

   // memory write port
   logic             wr_en_in;
   logic [IDX_W-1:0] wr_idx_in;
   logic             st_wr_in;
   logic [IDX_W-1:0] st_idx_in;

   logic             scan_issue;
   logic [31:0]      age_in;
   logic [IDX_W-1:0] rec_tgt_in;
   logic [63:0]      rec_gap_in;
   logic             rec_big_in;
   logic             csr_wr;

   assign scan_issue = (state_ff == S_SCAN) && (scan_ff < CNT_W'(MAX_RANGES));
   assign age_in     = stamp_ff - rd_stamp_ff;

   always_comb begin
      if (state_ff == S_REC_N) begin
         rec_tgt_in = free_idx_ff;
         rec_gap_in = n_start_ff - end_b_ff;
      end else begin
         rec_tgt_in = p_idx_ff;
         rec_gap_in = rec_head_ff - end_a_ff;
      end
   end
   assign rec_big_in = rec_gap_in >= {32'd0, min_gap_ff};

   assign wr_en_in  = (state_ff == S_EVAL) && (op_ff == OP_INSERT) && !match_ff && free_ff;
   assign wr_idx_in = free_idx_ff;
   assign st_wr_in  = ((state_ff == S_REC_P && has_p_ff) || state_ff == S_REC_N)
                      && !onfree_ff[rec_tgt_in] && rec_big_in;
   assign st_idx_in = rec_tgt_in;

   always_ff @(posedge clock) begin
      if (wr_en_in) begin
         start_mem[wr_idx_in]  <= key_ff;
         length_mem[wr_idx_in] <= len_ff;
      end
      if (st_wr_in) stamp_mem[st_idx_in] <= stamp_ff;
      rd_start_ff <= start_mem[scan_ff[IDX_W-1:0]];
      rd_len_ff   <= length_mem[scan_ff[IDX_W-1:0]];
      rd_stamp_ff <= stamp_mem[scan_ff[IDX_W-1:0]];
   end

   // configuration
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MIN_GAP) ? min_gap_ff : 32'd0;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         onfree_ff    <= '0;
         stamp_ff     <= '0;
         min_gap_ff   <= MIN_GAP_RESET;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         scan_ff      <= '0;
      end else begin
         if (csr_wr && csr_paddr[2] == REG_MIN_GAP) min_gap_ff <= csr_pwdata;
         // in S_DONE the output register is reloaded below
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) rsp_valid_ff <= 1'b0;

         rd_vld_ff <= scan_issue;
         rd_idx_ff <= scan_ff[IDX_W-1:0];
         if (scan_issue) scan_ff <= scan_ff + CNT_W'(1);

         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff     <= opcode_type'(req_tuser);
                  key_ff    <= req_tdata[63:0];
                  len_ff    <= req_tdata[127:64];
                  scan_ff   <= '0;
                  match_ff  <= 1'b0;
                  free_ff   <= 1'b0;
                  has_p_ff  <= 1'b0;
                  has_n_ff  <= 1'b0;
                  has_b_ff  <= 1'b0;
                  status_ff <= ST_OK;
                  addr_ff   <= '0;
                  if (opcode_type'(req_tuser) == OP_CLEAR) begin
                     valid_ff  <= '0;
                     onfree_ff <= '0;
                     state_ff  <= S_DONE;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (rd_vld_ff) begin
                  if (valid_ff[rd_idx_ff] && rd_start_ff == key_ff) begin
                     match_ff     <= 1'b1;
                     match_idx_ff <= rd_idx_ff;
                  end
                  if (!valid_ff[rd_idx_ff] && !free_ff) begin
                     free_ff     <= 1'b1;
                     free_idx_ff <= rd_idx_ff;
                  end
                  if (valid_ff[rd_idx_ff] && rd_start_ff < key_ff &&
                      (!has_p_ff || rd_start_ff > p_start_ff)) begin
                     has_p_ff   <= 1'b1;
                     p_idx_ff   <= rd_idx_ff;
                     p_start_ff <= rd_start_ff;
                     p_len_ff   <= rd_len_ff;
                  end
                  if (valid_ff[rd_idx_ff] && rd_start_ff > key_ff &&
                      (!has_n_ff || rd_start_ff < n_start_ff)) begin
                     has_n_ff   <= 1'b1;
                     n_start_ff <= rd_start_ff;
                  end
                  // strict compare: lowest slot wins on equal age
                  if (valid_ff[rd_idx_ff] && onfree_ff[rd_idx_ff] &&
                      (!has_b_ff || age_in < b_age_ff)) begin
                     has_b_ff   <= 1'b1;
                     b_start_ff <= rd_start_ff;
                     b_len_ff   <= rd_len_ff;
                     b_age_ff   <= age_in;
                  end
                  if (rd_idx_ff == LAST_IDX) state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               end_a_ff <= p_start_ff + p_len_ff;
               end_b_ff <= key_ff + len_ff;
               priority case (op_ff)
                  OP_INSERT: begin
                     rec_head_ff <= key_ff;
                     if (match_ff) begin
                        status_ff <= ST_DUP;
                        state_ff  <= S_DONE;
                     end else if (!free_ff) begin
                        status_ff <= ST_FULL;
                        state_ff  <= S_DONE;
                     end else begin
                        valid_ff[free_idx_ff]  <= 1'b1;
                        onfree_ff[free_idx_ff] <= 1'b0;
                        if (has_p_ff)      state_ff <= S_REC_P;
                        else if (has_n_ff) state_ff <= S_REC_N;
                        else               state_ff <= S_DONE;
                     end
                  end
                  OP_REMOVE: begin
                     rec_head_ff <= n_start_ff;
                     if (match_ff) begin
                        valid_ff[match_idx_ff]  <= 1'b0;
                        onfree_ff[match_idx_ff] <= 1'b0;
                     end
                     if (match_ff && has_p_ff && has_n_ff) state_ff <= S_REC_P;
                     else                                  state_ff <= S_DONE;
                  end
                  default: begin
                     if (has_b_ff) addr_ff <= b_start_ff + b_len_ff;
                     else          status_ff <= ST_EMPTY;
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_REC_P, S_REC_N: begin
               if (st_wr_in) begin
                  onfree_ff[rec_tgt_in] <= 1'b1;
                  stamp_ff              <= stamp_ff + 32'd1;
               end else if (onfree_ff[rec_tgt_in] && !rec_big_in) begin
                  onfree_ff[rec_tgt_in] <= 1'b0;
               end
               if (state_ff == S_REC_P && op_ff == OP_INSERT && has_n_ff)
                  state_ff <= S_REC_N;
               else
                  state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= status_ff;
                  rsp_addr_ff   <= addr_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_free_implies_valid: assert property (@(posedge clock) disable iff (reset)
      (onfree_ff & ~valid_ff) == '0)
      else $error("free mark on an empty slot");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted a second item while busy");

   a_addr_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_addr_ff == 64'd0)
      else $error("nonzero address on a failed result");

   a_stamp_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> stamp_ff == $past(stamp_ff) || stamp_ff == $past(stamp_ff) + 32'd1)
      else $error("stamp counter jumped");

endmodule

// ----- dv/tb_iova_interval_gap_allocator.sv -----
// Self-checking testbench for the IOVA interval gap allocator.
module tb_iova_interval_gap_allocator;
   import iiga_pkg::*;

   localparam int SLOTS = 64;

   typedef struct packed {
      opcode_type  op;
      logic [63:0] start;
      logic [63:0] len;
   } range_req_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] addr;
   } range_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [127:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   iova_interval_gap_allocator u_dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [63:0] tbl_start [SLOTS];
   logic [63:0] tbl_len [SLOTS];
   logic        tbl_used [SLOTS];
   logic        tbl_marked [SLOTS];
   logic [31:0] tbl_stamp [SLOTS];
   logic [31:0] next_stamp;
   logic [31:0] gap_floor;

   range_req_type pending_reqs[$];
   range_rsp_type expected_rsps[$];
   logic [63:0] live_keys[$];
   int errors = 0;
   int req_wait = 0;
   int rsp_wait = 0;
   bit hold_sender = 1'b0;

   function automatic int slot_of(logic [63:0] key);
      for (int i = 0; i < SLOTS; i++)
         if (tbl_used[i] && tbl_start[i] == key) return i;
      return -1;
   endfunction

   // nearest neighbor below (dir 0) or above (dir 1) the key
   function automatic int neighbor_of(logic [63:0] key, bit dir);
      int best = -1;
      for (int i = 0; i < SLOTS; i++)
         if (tbl_used[i] && (dir ? tbl_start[i] > key : tbl_start[i] < key) &&
             (best < 0 || (dir ? tbl_start[i] < tbl_start[best]
                               : tbl_start[i] > tbl_start[best])))
            best = i;
      return best;
   endfunction

   function automatic void remark(int t, int n);
      logic [63:0] gap;
      bit wide;
      gap = tbl_start[n] - (tbl_start[t] + tbl_len[t]);
      wide = gap >= {32'd0, gap_floor};
      if (!tbl_marked[t] && wide) begin
         tbl_marked[t] = 1'b1;
         tbl_stamp[t] = next_stamp;
         next_stamp++;
      end else if (tbl_marked[t] && !wide) begin
         tbl_marked[t] = 1'b0;
      end
   endfunction

   function automatic range_rsp_type apply_request(range_req_type r);
      range_rsp_type res;
      int s, p, n, best;
      logic [31:0] age, best_age;
      res = '{ST_OK, 64'd0};
      best = -1;
      best_age = '0;
      case (r.op)
         OP_INSERT: begin
            s = -1;
            if (slot_of(r.start) >= 0) begin
               res.status = ST_DUP;
            end else begin
               for (int i = SLOTS - 1; i >= 0; i--)
                  if (!tbl_used[i]) s = i;
               if (s < 0) begin
                  res.status = ST_FULL;
               end else begin
                  p = neighbor_of(r.start, 1'b0);
                  n = neighbor_of(r.start, 1'b1);
                  tbl_start[s] = r.start;
                  tbl_len[s] = r.len;
                  tbl_used[s] = 1'b1;
                  tbl_marked[s] = 1'b0;
                  if (p >= 0) remark(p, s);
                  if (n >= 0) remark(s, n);
               end
            end
         end
         OP_REMOVE: begin
            s = slot_of(r.start);
            if (s >= 0) begin
               p = neighbor_of(r.start, 1'b0);
               n = neighbor_of(r.start, 1'b1);
               if (p >= 0 && n >= 0) remark(p, n);
               tbl_marked[s] = 1'b0;
               tbl_used[s] = 1'b0;
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < SLOTS; i++) begin
               tbl_used[i] = 1'b0;
               tbl_marked[i] = 1'b0;
            end
         end
         default: begin
            for (int i = 0; i < SLOTS; i++)
               if (tbl_used[i] && tbl_marked[i]) begin
                  age = next_stamp - tbl_stamp[i];
                  if (best < 0 || age < best_age) begin
                     best = i;
                     best_age = age;
                  end
               end
            if (best < 0) res.status = ST_EMPTY;
            else res.addr = tbl_start[best] + tbl_len[best];
         end
      endcase
      return res;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         expected_rsps.push_back(apply_request(range_req_type'{opcode_type'(req_tuser),
                                                               req_tdata[63:0],
                                                               req_tdata[127:64]}));
         req_tvalid <= 1'b0;
         req_wait = $urandom_range(0, 13);
      end else if (!req_tvalid) begin
         if (req_wait > 0) begin
            req_wait--;
         end else if (!hold_sender && pending_reqs.size() > 0) begin
            range_req_type r;
            r = pending_reqs.pop_front();
            req_tuser <= r.op;
            req_tdata <= {r.len, r.start};
            req_tvalid <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result: status %0d addr %h", rsp_tuser, rsp_tdata);
            end else begin
               range_rsp_type e;
               e = expected_rsps.pop_front();
               if (e.status !== rsp_tuser || e.addr !== rsp_tdata) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp status %0d addr %h, got status %0d addr %h",
                              e.status, e.addr, rsp_tuser, rsp_tdata);
               end
            end
            rsp_wait = $urandom_range(0, 13);
            rsp_tready <= (rsp_wait == 0);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= (rsp_wait == 0);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_min_gap(logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {REG_MIN_GAP, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      gap_floor = value;
   endtask

   function automatic void queue_req(opcode_type op, logic [63:0] start, logic [63:0] len);
      pending_reqs.push_back('{op, start, len});
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // mostly well-formed traffic: keys near a base, lengths up to 0x3000
   function automatic void queue_random(int count, logic [63:0] base);
      int sel;
      logic [63:0] k;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 45) begin
            k = base + 64'($urandom_range(0, 255)) * 64'h2000;
            queue_req(OP_INSERT, k, 64'($urandom_range(0, 16'h3000)));
            live_keys.push_back(k);
         end else if (sel < 65 && live_keys.size() > 0) begin
            queue_req(OP_REMOVE, live_keys[$urandom_range(0, live_keys.size() - 1)], rand64());
         end else if (sel < 90) begin
            queue_req(OP_FIND, rand64(), rand64());
         end else if (sel < 92) begin
            queue_req(OP_CLEAR, rand64(), rand64());
            live_keys.delete();
         end else if (sel < 96) begin
            queue_req(OP_REMOVE, rand64(), rand64());
         end else begin
            queue_req(OP_INSERT, rand64(), rand64());
         end
      end
   endfunction

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         tbl_used[i] = 1'b0;
         tbl_marked[i] = 1'b0;
      end
      next_stamp = '0;
      gap_floor = MIN_GAP_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty find, extremes, duplicate, wrap, remove absent, clear
      queue_req(OP_FIND, '0, '0);
      queue_req(OP_REMOVE, 64'h1000, '0);
      queue_req(OP_INSERT, '0, '0);
      queue_req(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      queue_req(OP_INSERT, 64'h10000, 64'h100);
      queue_req(OP_INSERT, 64'h10000, 64'h5);
      queue_req(OP_FIND, '0, '0);
      queue_req(OP_INSERT, 64'h10200, 64'hFFFF_FFFF_FFFF_0000);
      queue_req(OP_FIND, '0, '0);
      queue_req(OP_INSERT, 64'h8000_0000_0000_0000, 64'h10);
      queue_req(OP_REMOVE, 64'h10200, '0);
      queue_req(OP_FIND, '0, '0);
      queue_req(OP_REMOVE, 64'h10000, '0);
      queue_req(OP_FIND, '0, '0);
      queue_req(OP_CLEAR, '0, '0);
      queue_req(OP_FIND, '0, '0);
      // fill the table, then overflow
      for (int i = 0; i < SLOTS; i++)
         queue_req(OP_INSERT, 64'(i) * 64'h4000, 64'(i) * 64'h80);
      queue_req(OP_INSERT, 64'h7777_0000, 64'h1);
      queue_req(OP_FIND, '0, '0);
      queue_req(OP_CLEAR, '0, '0);
      hold_sender = 1'b0;
      wait_drained();

      write_min_gap(32'd1);
      queue_random(300, 64'h1_0000_0000);
      wait_drained();
      write_min_gap(32'hFFFF_FFFF);
      queue_random(200, 64'hFFFF_FFFF_FFF0_0000);
      queue_req(OP_INSERT, 64'hFFFF_FFFF_0000_0000, 64'h0);
      queue_req(OP_INSERT, 64'h0000_0000_0000_0000, 64'h0);
      queue_req(OP_FIND, '0, '0);
      wait_drained();
      write_min_gap(32'h8000_0000);
      queue_random(100, {$urandom(), 32'd0});
      wait_drained();
      write_min_gap(32'h0000_1800);
      queue_random(450, 64'h4000_0000_0000);
      // mid-stream, the sender holds until every result is back
      while (pending_reqs.size() > 225) @(posedge clock);
      hold_sender = 1'b1;
      while (req_tvalid || expected_rsps.size() > 0) @(posedge clock);
      hold_sender = 1'b0;
      queue_random(450, 64'h4000_0000_0000);
      wait_drained();
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
